FILE: hdl/gray_to_lcd_page_packer_macros.svh
// Assertion helpers for the checker of the LCD page packer.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef GRAY_TO_LCD_PAGE_PACKER_MACROS_SVH
`define GRAY_TO_LCD_PAGE_PACKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GLPP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glpp check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define GLPP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glpp check failed one cycle later");

`endif

FILE: hdl/glpp_pkg.sv
package glpp_pkg;

	localparam int MAX_WIDTH_DEF = 256;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int IMG_W_BITS = 9;
	localparam int IMG_H_BITS = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FORMAT = 2'd0,
		CFG_WIDTH  = 2'd1,
		CFG_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		FMT_VPAGE = 2'd0,  // vertical mono pages, 8 rows per band
		FMT_HMONO = 2'd1,  // horizontal mono, 8 columns per byte
		FMT_GREY4 = 2'd2,  // four-grey pages, 4 rows per band
		FMT_GREY8 = 2'd3   // one grey byte per pixel
	} fmt_t;

	typedef struct packed {
		logic [7:0] pixel_red;
		logic [7:0] pixel_green;
		logic [7:0] pixel_blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] packed_byte;
		logic       end_of_image;
	} result_t;

	// Luma weights and divide-by-ten through a reciprocal.
	localparam int SUM_W       = 12;
	localparam int LUMA_R_COEF = 3;
	localparam int LUMA_G_COEF = 6;
	localparam int LUMA_B_COEF = 1;
	localparam int GREY_DIV    = 10;
	localparam int GREY_SHIFT  = 16;
	localparam int GREY_RECIP  = (1 << GREY_SHIFT) / GREY_DIV + 1;
	localparam int RECIP_W     = 13;
	localparam int PROD_W      = SUM_W + RECIP_W;

	localparam logic [7:0] DARK_MASK = 8'h80;
	localparam logic [7:0] QUAD_MASK = 8'hC0;

	// Output queue: room for queued beats, the beat in stage 1 and the pixel just taken.
	localparam int QDEPTH = 3;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

endpackage

FILE: hdl/glpp_stream_if.sv
interface glpp_stream_if #(
	parameter type payload_t = logic [7:0]
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);
endinterface

FILE: hdl/glpp_out_queue.sv
module glpp_out_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  glpp_pkg::result_t              push_data,
	output logic [glpp_pkg::QLVL_W-1:0]    level,
	glpp_stream_if.source                  res
);
	import glpp_pkg::*;

	result_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QLVL_W-1:0]   level_q;
	logic                pop;

	assign pop       = res.valid && res.ready;
	assign res.valid = (level_q != '0);
	assign res.data  = entry_q[rd_ptr_q];
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(pop);
		end
	end
endmodule

FILE: hdl/gray_to_lcd_page_packer.sv
// RGB to LCD page packer. Takes one RGB pixel beat per clock in raster order, while
// the output queue has room, and computes grey = (3R + 6G + B) / 10, then packs it
// into the layout chosen by the format register: vertical mono pages (8-row bands),
// horizontal mono (8 columns a byte), four-grey pages (4-row bands) or plain grey
// bytes. Band layouts keep the partly built byte of each column in a line store
// of MAX_WIDTH bytes, which is read when the pixel is taken and written back in
// the next cycle; a read that meets the write of the previous pixel to the same
// column takes the written byte instead. The block sustains one pixel per clock
// while the sink keeps taking results; a result beat passes through the stage-1
// registers and the output queue, and the three-entry output queue lets pixels keep
// flowing while a result waits to be taken. Throughput is set by the single read
// and single write of the line store each cycle. The line store needs no clearing
// after reset: the first row of every band overwrites it. Configuration writes
// restart the image and are to be made only while the block is idle.
module gray_to_lcd_page_packer #(
	parameter int MAX_WIDTH = glpp_pkg::MAX_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [glpp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [glpp_pkg::CFG_DATA_W-1:0]    cfg_data,
	glpp_stream_if.sink                        pix,
	glpp_stream_if.source                      res
);
	import glpp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
	localparam int HW = IMG_H_BITS + 1;

	// Configuration.
	fmt_t                   fmt_q;
	logic [IMG_W_BITS-1:0]  width_q;
	logic [IMG_H_BITS-1:0]  height_q;
	logic                   restart;

	// Raster position and horizontal byte under construction.
	logic [CW-1:0]          col_q;
	logic [IMG_H_BITS-1:0]  row_q;
	logic [7:0]             hacc_q;

	// Stage 0 decode.
	logic                   pix_fire;
	logic                   last_col;
	logic                   last_row;
	logic [SUM_W-1:0]       luma_sum;

	// Stage 1.
	logic                   v_s1;
	logic [SUM_W-1:0]       sum_s1;
	logic [CW-1:0]          col_s1;
	logic [2:0]             row_sub_s1;
	logic                   last_col_s1;
	logic                   last_row_s1;

	// Line store and bypass.
	logic [7:0]             store_mem [MAX_WIDTH];
	logic [7:0]             rd_data_q;
	logic                   fwd_hit_q;
	logic [7:0]             fwd_data_q;

	// Stage 1 datapath.
	logic [PROD_W-1:0]      grey_prod;
	logic [7:0]             grey;
	logic [7:0]             inv_grey;
	logic [7:0]             old_byte;
	logic [7:0]             bits;
	logic [7:0]             new_byte;
	logic [1:0]             quad_sub;
	logic [2:0]             col_sub;
	logic                   store_we;
	logic                   hacc_we;
	logic                   emit;
	logic                   wr_en;
	logic                   push;
	result_t                push_data;
	logic [QLVL_W-1:0]      q_level;

	// ---------------------------------------------------------------
	// Configuration writes; a write to a listed register restarts the image.
	// ---------------------------------------------------------------
	always_comb begin
		case (cfg_idx_t'(cfg_index))
			CFG_FORMAT, CFG_WIDTH, CFG_HEIGHT: restart = cfg_we;
			default:                           restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= FMT_VPAGE;
			width_q  <= IMG_W_BITS'(1);
			height_q <= IMG_H_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FORMAT: fmt_q    <= fmt_t'(cfg_data[1:0]);
				CFG_WIDTH:  width_q  <= cfg_data[IMG_W_BITS-1:0];
				CFG_HEIGHT: height_q <= cfg_data[IMG_H_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage 0: take the pixel, find its place in the raster, read the store.
	// ---------------------------------------------------------------
	// Take a pixel only if a queue slot is free after the queued and stage-1 beats.
	assign pix.ready = ({1'b0, q_level} + (QLVL_W + 1)'(v_s1)) <= (QLVL_W + 1)'(QDEPTH - 1);
	assign pix_fire  = pix.valid && pix.ready;

	// Zero width counts as one; width beyond the store saturates at its depth.
	assign last_col = ((WW'(col_q) + WW'(1)) >= WW'(width_q)) ||
	                  (col_q == CW'(MAX_WIDTH - 1));
	// Zero height counts as one.
	assign last_row = ((HW'(row_q) + HW'(1)) >= HW'(height_q));

	assign luma_sum = SUM_W'(pix.data.pixel_red)   * SUM_W'(LUMA_R_COEF) +
	                  SUM_W'(pix.data.pixel_green) * SUM_W'(LUMA_G_COEF) +
	                  SUM_W'(pix.data.pixel_blue)  * SUM_W'(LUMA_B_COEF);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Carry the pixel into stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= pix_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			sum_s1      <= luma_sum;
			col_s1      <= col_q;
			row_sub_s1  <= row_q[2:0];
			last_col_s1 <= last_col;
			last_row_s1 <= last_row;
		end
	end

	// ---------------------------------------------------------------
	// Line store: one read in stage 0, one write-back in stage 1.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (pix_fire) begin
			rd_data_q <= store_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[col_s1] <= new_byte;
		end
	end

	// The read sees the old byte when stage 1 writes the same column in that
	// cycle (only with a one-pixel-wide image); hold the written byte instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (pix_fire) begin
			fwd_hit_q <= wr_en && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (pix_fire) begin
			fwd_data_q <= new_byte;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: grey value, merge into the byte, write back, push the beat.
	// ---------------------------------------------------------------
	assign grey_prod = PROD_W'(sum_s1) * PROD_W'(GREY_RECIP);
	assign grey      = grey_prod[GREY_SHIFT +: 8];
	assign inv_grey  = ~grey;
	assign old_byte  = fwd_hit_q ? fwd_data_q : rd_data_q;
	assign quad_sub  = row_sub_s1[1:0];
	assign col_sub   = col_s1[2:0];

	always_comb begin
		bits     = '0;
		new_byte = '0;
		store_we = 1'b0;
		hacc_we  = 1'b0;
		emit     = 1'b0;
		case (fmt_q)
			FMT_VPAGE: begin
				// Row r of the band lands in bit r.
				bits     = (inv_grey & DARK_MASK) >> (3'd7 - row_sub_s1);
				new_byte = (row_sub_s1 == 3'd0) ? bits : (old_byte | bits);
				store_we = 1'b1;
				emit     = (row_sub_s1 == 3'd7) || last_row_s1;
			end
			FMT_HMONO: begin
				// Leftmost column of the group lands in the MSB.
				bits     = (inv_grey & DARK_MASK) >> col_sub;
				new_byte = (col_sub == 3'd0) ? bits : (hacc_q | bits);
				hacc_we  = 1'b1;
				emit     = (col_sub == 3'd7) || last_col_s1;
			end
			FMT_GREY4: begin
				// Row r of the band lands in bits 2r+1..2r.
				bits     = (inv_grey & QUAD_MASK) >> {2'd3 - quad_sub, 1'b0};
				new_byte = (quad_sub == 2'd0) ? bits : (old_byte | bits);
				store_we = 1'b1;
				emit     = (quad_sub == 2'd3) || last_row_s1;
			end
			FMT_GREY8: begin
				new_byte = grey;
				emit     = 1'b1;
			end
			default: begin
				new_byte = grey;
				emit     = 1'b1;
			end
		endcase
	end

	assign wr_en = v_s1 && store_we;
	assign push  = v_s1 && emit;

	always_comb begin
		push_data.packed_byte  = new_byte;
		push_data.end_of_image = last_col_s1 && last_row_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hacc_q <= '0;
		end else if (restart) begin
			hacc_q <= '0;
		end else if (v_s1 && hacc_we) begin
			hacc_q <= new_byte;
		end
	end

	// ---------------------------------------------------------------
	// Output queue: holds result beats while the sink stalls.
	// ---------------------------------------------------------------
	glpp_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.level     (q_level),
		.res       (res)
	);
endmodule

FILE: hdl/glpp_checker.sv
`include "gray_to_lcd_page_packer_macros.svh"

module glpp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              pix_valid,
	input logic              pix_ready,
	input logic              res_valid,
	input logic              res_ready,
	input glpp_pkg::result_t res_data
);
	logic seen_q;

	// Remember that at least one pixel beat has gone in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (pix_valid && pix_ready) begin
			seen_q <= 1'b1;
		end
	end

	`GLPP_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_data))
	`GLPP_ASSERT_NEXT(a_drain_keeps_ready, res_ready, pix_ready)
	`GLPP_ASSERT_NOW(a_no_result_before_pixel, res_valid, seen_q)
endmodule

bind gray_to_lcd_page_packer glpp_checker u_glpp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pix.valid),
	.pix_ready (pix.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
